// ===== rtl/sparse_chunked_tile_store_unit_defines.svh =====
// Assertion macros shared by the sparse chunked tile store RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef SPARSE_CHUNKED_TILE_STORE_UNIT_DEFINES_SVH
`define SPARSE_CHUNKED_TILE_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SCTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/scts_pkg.sv =====
// Package of the sparse chunked tile store: payload structs, command and
// status structs, field widths, codes and parameter defaults. No dependencies.
`default_nettype none

package scts_pkg;

   localparam int CHUNK_SHIFT_DEF = 4;
   localparam int MAX_CHUNKS_DEF  = 64;
   localparam int TILE_BITS_DEF   = 8;

   localparam int COORD_W   = 32;
   localparam int VALUE_W   = 8;
   localparam int COUNT_W   = 7;
   localparam int PROD_W    = 2 * COUNT_W;
   localparam int SUM_W     = 3 * COUNT_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_COUNT_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_COUNT_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_COUNT_Z = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;

   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // value of a tile in an allocated chunk that was never written
   localparam logic [VALUE_W-1:0] UNWRITTEN_VALUE = 8'd1;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] abs_x;
      logic [COORD_W-1:0] abs_y;
      logic [COORD_W-1:0] abs_z;
      logic [VALUE_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] tile_value;
      logic               in_range;
      logic               chunk_was_present;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic calc1_en;
      logic calc2_en;
      logic rd_en;
      logic cnt_clr;
      logic cnt_inc;
      logic init_wr;
      logic present_wr;
      logic clr_wr;
      logic tile_wr;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_range;
      logic is_write;
      logic present;
      logic cnt_last_init;
      logic cnt_last_tile;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/scts_ctrl.sv =====
// Controller of the sparse chunked tile store: sequences one transaction at a
// time and owns the result valid flag. Depends on scts_pkg and the defines header.
`default_nettype none
`include "sparse_chunked_tile_store_unit_defines.svh"

module scts_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire scts_pkg::dp_status_type status,
   output scts_pkg::ctrl_cmd_type     cmd
);

   typedef enum logic [8:0] {
      S_INIT  = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_MUL   = 9'b000000100,
      S_IDX   = 9'b000001000,
      S_LOOK  = 9'b000010000,
      S_CHECK = 9'b000100000,
      S_CLEAR = 9'b001000000,
      S_WRITE = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.cnt_last_init) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.calc1_en = 1'b1;
            state_in     = S_IDX;
         end
         S_IDX: begin
            cmd.calc2_en = 1'b1;
            state_in     = S_LOOK;
         end
         S_LOOK: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (status.in_range && status.is_write) begin
               if (!status.present) begin
                  // first write allocates the chunk: mark it, then wipe its tiles
                  cmd.present_wr = 1'b1;
                  state_in       = S_CLEAR;
               end else begin
                  state_in = S_WRITE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.cnt_last_tile) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_WRITE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.tile_wr = 1'b1;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `SCTS_ASSERT_NEXT(a_accept_starts_calc, req_valid && req_ready, state_ff == S_MUL, "accepted transaction did not start the index calculation")
   `SCTS_ASSERT_NOW(a_rsp_load_free, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "result register overwritten before it was taken")
   `SCTS_ASSERT_NOW(a_tile_wr_legal, cmd.tile_wr || cmd.clr_wr, status.in_range && status.is_write, "tile memory written outside an in-range write")
   `SCTS_ASSERT_NEXT(a_alloc_sweeps, state_ff == S_CHECK && status.in_range && status.is_write && !status.present, state_ff == S_CLEAR, "allocating write skipped the tile wipe")

endmodule

`default_nettype wire

// ===== rtl/scts_dp.sv =====
// Datapath of the sparse chunked tile store: count registers, chunk index
// arithmetic, chunk presence and tile memories, result register. Uses scts_pkg.
`default_nettype none

module scts_dp #(
   parameter int CHUNK_SHIFT = scts_pkg::CHUNK_SHIFT_DEF,
   parameter int MAX_CHUNKS  = scts_pkg::MAX_CHUNKS_DEF,
   parameter int TILE_BITS   = scts_pkg::TILE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [scts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [scts_pkg::COUNT_W-1:0]      csr_wdata,
   input  wire scts_pkg::req_type                 req_payload,
   input  wire scts_pkg::ctrl_cmd_type            cmd,
   output scts_pkg::dp_status_type                status,
   output scts_pkg::rsp_type                      rsp_payload
);

   localparam int TIDX_W          = 2 * CHUNK_SHIFT;
   localparam int TILES_PER_CHUNK = 1 << TIDX_W;
   localparam int TILE_TOTAL      = MAX_CHUNKS * TILES_PER_CHUNK;
   localparam int CIDX_W          = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int ADDR_W          = CIDX_W + TIDX_W;
   localparam int CNT_W           = (CIDX_W > TIDX_W) ? CIDX_W : TIDX_W;
   localparam int ENTRY_W         = TILE_BITS + 1;
   localparam int COORD_W         = scts_pkg::COORD_W;
   localparam int COUNT_W         = scts_pkg::COUNT_W;
   localparam int PROD_W          = scts_pkg::PROD_W;
   localparam int SUM_W           = scts_pkg::SUM_W;
   localparam int VALUE_W         = scts_pkg::VALUE_W;

   // count registers
   logic [COUNT_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      if (csr_wr_en) begin
         case (csr_index)
            scts_pkg::CSR_CHUNK_COUNT_X: cx_in = csr_wdata;
            scts_pkg::CSR_CHUNK_COUNT_Y: cy_in = csr_wdata;
            scts_pkg::CSR_CHUNK_COUNT_Z: cz_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= scts_pkg::COUNT_RESET;
         cy_ff <= scts_pkg::COUNT_RESET;
         cz_ff <= scts_pkg::COUNT_RESET;
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
   end

   // request and index arithmetic
   scts_pkg::req_type  req_ff;
   logic [PROD_W-1:0]  cxy_ff, cxy_in, ycx_ff, ycx_in;
   logic               coord_ok_ff, coord_ok_in;
   logic [SUM_W-1:0]   chunk_sum;
   logic [CIDX_W-1:0]  chunk_ff, chunk_in;
   logic               in_range_ff, in_range_in;

   always_comb begin
      coord_ok_in = ((req_ff.abs_x >> CHUNK_SHIFT) < COORD_W'(cx_ff))
                 && ((req_ff.abs_y >> CHUNK_SHIFT) < COORD_W'(cy_ff))
                 && (req_ff.abs_z < COORD_W'(cz_ff));
      cxy_in      = PROD_W'(cx_ff) * PROD_W'(cy_ff);
      ycx_in      = PROD_W'(req_ff.abs_y[CHUNK_SHIFT +: COUNT_W]) * PROD_W'(cx_ff);
      chunk_sum   = SUM_W'(req_ff.abs_z[COUNT_W-1:0]) * SUM_W'(cxy_ff)
                  + SUM_W'(ycx_ff)
                  + SUM_W'(req_ff.abs_x[CHUNK_SHIFT +: COUNT_W]);
      in_range_in = coord_ok_ff && (chunk_sum < SUM_W'(MAX_CHUNKS));
      chunk_in    = chunk_sum[CIDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.calc1_en) begin
         cxy_ff      <= cxy_in;
         ycx_ff      <= ycx_in;
         coord_ok_ff <= coord_ok_in;
      end
      if (cmd.calc2_en) begin
         chunk_ff    <= chunk_in;
         in_range_ff <= in_range_in;
      end
   end

   // sweep counter: presence wipe after reset, tile wipe on allocation
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // chunk presence memory
   logic              pres_mem [MAX_CHUNKS];
   logic              pres_rd_ff;
   logic [CIDX_W-1:0] pres_addr;
   logic              pres_we, pres_re;

   assign pres_addr = cmd.init_wr ? cnt_ff[CIDX_W-1:0] : chunk_ff;
   assign pres_we   = cmd.init_wr || cmd.present_wr;
   assign pres_re   = cmd.rd_en && in_range_ff;

   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[pres_addr] <= cmd.present_wr;
      end
      if (pres_re) begin
         pres_rd_ff <= pres_mem[pres_addr];
      end
   end

   // tile memory: written flag on top of the stored value
   logic [ENTRY_W-1:0] tile_mem [TILE_TOTAL];
   logic [ENTRY_W-1:0] tile_rd_ff, tile_wdata;
   logic [ADDR_W-1:0]  tile_addr;
   logic               tile_we, tile_re;

   always_comb begin
      if (cmd.clr_wr) begin
         tile_addr  = {chunk_ff, cnt_ff[TIDX_W-1:0]};
         tile_wdata = '0;
      end else begin
         tile_addr  = {chunk_ff, req_ff.abs_y[CHUNK_SHIFT-1:0],
                       req_ff.abs_x[CHUNK_SHIFT-1:0]};
         tile_wdata = {1'b1, TILE_BITS'(req_ff.write_value)};
      end
      tile_we = cmd.clr_wr || cmd.tile_wr;
      tile_re = cmd.rd_en && in_range_ff;
   end

   always_ff @(posedge clock) begin
      if (tile_we) begin
         tile_mem[tile_addr] <= tile_wdata;
      end
      if (tile_re) begin
         tile_rd_ff <= tile_mem[tile_addr];
      end
   end

   // result register
   scts_pkg::rsp_type  rsp_ff, rsp_in;
   logic [VALUE_W-1:0] rd_value;
   logic               is_read;

   always_comb begin
      is_read  = (req_ff.mode == scts_pkg::MODE_READ);
      rd_value = tile_rd_ff[TILE_BITS] ? VALUE_W'(tile_rd_ff[TILE_BITS-1:0])
                                       : scts_pkg::UNWRITTEN_VALUE;
      rsp_in.in_range          = in_range_ff;
      rsp_in.chunk_was_present = in_range_ff && pres_rd_ff;
      rsp_in.tile_value        = (in_range_ff && is_read && pres_rd_ff) ? rd_value : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload          = rsp_ff;
   assign status.in_range      = in_range_ff;
   assign status.is_write      = (req_ff.mode == scts_pkg::MODE_WRITE);
   assign status.present       = pres_rd_ff;
   assign status.cnt_last_init = (cnt_ff == CNT_W'(MAX_CHUNKS - 1));
   assign status.cnt_last_tile = (cnt_ff == CNT_W'(TILES_PER_CHUNK - 1));

endmodule

`default_nettype wire

// ===== rtl/sparse_chunked_tile_store_unit.sv =====
// Sparse chunked tile store, top level: a controller and a datapath.
// Each req_ transaction reads (mode 0) or writes (mode 1) one tile at abs_x,
// abs_y, abs_z. The bits of abs_x and abs_y above CHUNK_SHIFT pick the chunk
// column and row, abs_z the layer; the chunk index is z*cy*cx + y*cx + x.
// Each transaction returns exactly one rsp_ transaction: the tile value (0 out
// of range, unallocated or for a write, 1 for a never-written tile of an
// allocated chunk), the in-range flag and whether the chunk existed before.
// Sequence: an accepted request passes the index multiply, index, lookup and
// check states; a write to an allocated chunk then writes its tile, and the
// first write to a chunk first wipes that chunk's tiles one memory entry per
// cycle. rsp_valid rises when the result register loads, which waits for
// rsp_ready while an earlier result is still held. One transaction at a time;
// the index multiply is split over two register steps, and the presence and
// tile memories are read synchronously.
// Reset: counts return to 1 and the presence memory is cleared one chunk per
// cycle with req_ready low; csr_ writes are taken anyway.
// Stall: the result sits in an output register; the next transaction is taken
// and processed, and it waits only to load that register until rsp_ready.
// The user must write the count registers through csr_ only while the unit is idle; the unit does not enforce this.
`default_nettype none

module sparse_chunked_tile_store_unit #(
   parameter int CHUNK_SHIFT = scts_pkg::CHUNK_SHIFT_DEF,
   parameter int MAX_CHUNKS  = scts_pkg::MAX_CHUNKS_DEF,
   parameter int TILE_BITS   = scts_pkg::TILE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // count register write port
   input  wire logic                           csr_wr_en,
   input  wire logic [scts_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [scts_pkg::COUNT_W-1:0]   csr_wdata,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire scts_pkg::req_type              req_payload,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output scts_pkg::rsp_type                   rsp_payload
);

   scts_pkg::ctrl_cmd_type  cmd;
   scts_pkg::dp_status_type status;

   // sequence each transaction and hold the result valid flag
   scts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // compute the chunk index, access the memories, build the result
   scts_dp #(
      .CHUNK_SHIFT (CHUNK_SHIFT),
      .MAX_CHUNKS  (MAX_CHUNKS),
      .TILE_BITS   (TILE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
